/* rtl/wcf_pkg.sv */
// Shared types, codes and defaults for the word concatenation finder.
package wcf_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned MAX_WORD_LEN_DEF    = 16;
  localparam int unsigned MAX_WORDS_DEF       = 16;
  localparam int unsigned TEXT_INDEX_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MATCH_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_DICT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  // Register indexes (byte address bit 2)
  localparam logic REG_WORD_LEN   = 1'b0;
  localparam logic REG_WORD_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DFIN,
    S_MISS,
    S_W_INIT,
    S_W_UPD,
    S_SH_HEAD,
    S_SH_OLD,
    S_SH_DEC,
    S_APPEND
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ph_sub;
    logic ph_step;
    logic srch_cmp;
    logic dict_fin;
    logic miss;
    logic w_init;
    logic w_inc;
    logic sh_cnt;
    logic sh_dec;
    logic append;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_text;
    logic dict_end;
    logic ph_big;
    logic fill_short;
    logic srch_more;
    logic srch_eq;
    logic mode_dict;
    logic cnt_over;
    logic win_empty;
    logic old_is_id;
    logic out_blocked;
  } sts_t;

endpackage

/* rtl/word_concatenation_finder_unit.sv */
// Top level of the word concatenation finder: register port, controller and datapath.
// Sequence: at a dictionary word end, earlier words are compared one by one to find a
// duplicate. A text character first fixes its phase, then is compared with each dictionary
// word; an unknown word empties the window, while a known one updates it, drops the front up to
// its earlier copy when its count is exceeded, and is appended, which may load the result.
// Throughput: one item at a time; the input stalls until the search, the window update and
// a stalled result are done. Async active-low reset clears control state and count valid bits.
module word_concatenation_finder_unit #(
  parameter int unsigned MAX_WORD_LEN    = wcf_pkg::MAX_WORD_LEN_DEF,
  parameter int unsigned MAX_WORDS       = wcf_pkg::MAX_WORDS_DEF,
  parameter int unsigned TEXT_INDEX_BITS = wcf_pkg::TEXT_INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wcf_pkg::REQ_W-1:0]   req_type_i,
  input  logic [wcf_pkg::CHAR_W-1:0]  char_byte_i,
  output logic                        match_valid_o,
  input  logic                        match_stall_i,
  output logic [wcf_pkg::MATCH_W-1:0] match_start_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wcf_pkg::*;

  logic [CFG_W-1:0] word_len_q, word_count_q;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q   <= CFG_W'(1);
      word_count_q <= CFG_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WORD_COUNT) begin
        word_count_q <= pwdata[CFG_W-1:0];
      end else begin
        word_len_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_WORD_LEN) ? {{(32-CFG_W){1'b0}}, word_len_q}
                                             : {{(32-CFG_W){1'b0}}, word_count_q};
  assign pready = 1'b1;

  wcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wcf_dp #(
    .MAX_WORD_LEN    (MAX_WORD_LEN),
    .MAX_WORDS       (MAX_WORDS),
    .TEXT_INDEX_BITS (TEXT_INDEX_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .word_len_i    (word_len_q),
    .word_count_i  (word_count_q),
    .req_type_i    (req_type_i),
    .char_byte_i   (char_byte_i),
    .match_valid_o (match_valid_o),
    .match_stall_i (match_stall_i),
    .match_start_o (match_start_o)
  );

endmodule

/* rtl/wcf_ctrl.sv */
// Sequencing state machine of the word concatenation finder.
module wcf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wcf_pkg::sts_t sts_i,
  output wcf_pkg::cmd_t cmd_o
);
  import wcf_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.req_text) begin
            state_d = S_PHASE;
          end else if (sts_i.dict_end) begin
            state_d = S_SRCH_RD;
          end
        end
      end
      S_PHASE: begin
        if (!sts_i.ph_big) begin
          state_d = sts_i.fill_short ? S_IDLE : S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts_i.srch_more) begin
          state_d = S_SRCH_CMP;
        end else begin
          state_d = sts_i.mode_dict ? S_DFIN : S_MISS;
        end
      end
      S_SRCH_CMP: begin
        if (sts_i.srch_eq) begin
          state_d = sts_i.mode_dict ? S_DFIN : S_W_INIT;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_DFIN:    state_d = S_IDLE;
      S_MISS:    state_d = S_IDLE;
      S_W_INIT:  state_d = S_W_UPD;
      S_W_UPD:   state_d = sts_i.cnt_over ? S_SH_HEAD : S_APPEND;
      S_SH_HEAD: state_d = sts_i.win_empty ? S_APPEND : S_SH_OLD;
      S_SH_OLD:  state_d = S_SH_DEC;
      S_SH_DEC:  state_d = sts_i.old_is_id ? S_APPEND : S_SH_HEAD;
      S_APPEND: begin
        if (!sts_i.out_blocked) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.accept   = in_valid_i;
      S_PHASE: begin
        cmd_o.ph_sub  = sts_i.ph_big;
        cmd_o.ph_step = !sts_i.ph_big;
      end
      S_SRCH_CMP: cmd_o.srch_cmp = 1'b1;
      S_DFIN:     cmd_o.dict_fin = 1'b1;
      S_MISS:     cmd_o.miss     = 1'b1;
      S_W_INIT:   cmd_o.w_init   = 1'b1;
      S_W_UPD:    cmd_o.w_inc    = 1'b1;
      S_SH_OLD:   cmd_o.sh_cnt   = 1'b1;
      S_SH_DEC:   cmd_o.sh_dec   = 1'b1;
      S_APPEND:   cmd_o.append   = !sts_i.out_blocked;
      default:    cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* rtl/wcf_dp.sv */
// Datapath: dictionary store, text history, per-phase windows and result register.
module wcf_dp #(
  parameter int unsigned MAX_WORD_LEN    = wcf_pkg::MAX_WORD_LEN_DEF,
  parameter int unsigned MAX_WORDS       = wcf_pkg::MAX_WORDS_DEF,
  parameter int unsigned TEXT_INDEX_BITS = wcf_pkg::TEXT_INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wcf_pkg::cmd_t                 cmd_i,
  output wcf_pkg::sts_t                 sts_o,
  input  logic [wcf_pkg::CFG_W-1:0]     word_len_i,
  input  logic [wcf_pkg::CFG_W-1:0]     word_count_i,
  input  logic [wcf_pkg::REQ_W-1:0]     req_type_i,
  input  logic [wcf_pkg::CHAR_W-1:0]    char_byte_i,
  output logic                          match_valid_o,
  input  logic                          match_stall_i,
  output logic [wcf_pkg::MATCH_W-1:0]   match_start_o
);
  import wcf_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned PW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int unsigned KW    = $clog2(MAX_WORDS + 1);
  localparam int unsigned ID_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW    = KW + 1;
  localparam int unsigned SLOTS = MAX_WORD_LEN * MAX_WORDS;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIB   = TEXT_INDEX_BITS;

  typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] word_t;

  function automatic logic [SW-1:0] slot(input logic [PW-1:0] ph, input logic [ID_W-1:0] id);
    slot = SW'(ph) * SW'(MAX_WORDS) + SW'(id);
  endfunction

  // Effective register values, clamped to the supported range
  logic [6:0]       wl_x, wc_x;
  logic [LEN_W-1:0] len_eff;
  logic [KW-1:0]    cnt_eff;

  assign wl_x    = {2'b0, word_len_i};
  assign wc_x    = {2'b0, word_count_i};
  assign len_eff = (wl_x == 7'd0) ? LEN_W'(1) :
                   (wl_x > 7'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : LEN_W'(wl_x);
  assign cnt_eff = (wc_x == 7'd0) ? KW'(1) :
                   (wc_x > 7'(MAX_WORDS)) ? KW'(MAX_WORDS) : KW'(wc_x);

  // State
  logic [KW-1:0]     dk_q;
  logic [PW-1:0]     dpos_q;
  word_t             stage_q;
  logic [ID_W-1:0]   ident_q [MAX_WORDS];
  logic [KW-1:0]     reqc_q [MAX_WORDS];
  logic [CHAR_W-1:0] rec_q [MAX_WORD_LEN];
  logic [LEN_W-1:0]  fill_q;
  logic [TIB-1:0]    tpos_q;
  logic [PW-1:0]     phase_q;
  logic [PW-1:0]     ph_q;
  logic [TIB-1:0]    start_q;
  logic              mode_dict_q;
  logic [KW-1:0]     j_q;
  logic [ID_W-1:0]   id_q;
  logic [ID_W-1:0]   old_q;
  logic [TIB-1:0]    wstart_q [MAX_WORD_LEN];
  logic [KW-1:0]     matched_q [MAX_WORD_LEN];
  logic [ID_W-1:0]   head_q [MAX_WORD_LEN];
  logic              out_v_q;
  logic [TIB-1:0]    out_q;

  // Memories
  word_t             dmem [MAX_WORDS];
  word_t             dm_rd_q;
  logic [CW-1:0]     cmem [SLOTS];
  logic              cvld_q [SLOTS];
  logic [CW-1:0]     c_rd_q;
  logic              c_rv_q;
  logic [ID_W-1:0]   hmem [SLOTS];
  logic [ID_W-1:0]   h_rd_q;

  // Item decode
  logic dict_acc, text_acc, restart;
  logic dict_open, word_end;
  logic [7:0] pos_inc8;
  word_t new_word;

  assign dict_acc  = cmd_i.accept && (req_type_i == REQ_DICT);
  assign text_acc  = cmd_i.accept && (req_type_i == REQ_TEXT);
  assign restart   = cmd_i.accept && (req_type_i == REQ_RESTART);
  assign dict_open = 8'(dk_q) < 8'(cnt_eff);
  assign pos_inc8  = 8'(dpos_q) + 8'd1;
  assign word_end  = dict_open && (pos_inc8 >= 8'(len_eff));

  // Merge the incoming character into the word being assembled
  always_comb begin
    new_word = stage_q;
    new_word[dpos_q] = char_byte_i;
  end

  // Align the newest word_len text characters to character positions
  word_t cand, target;
  always_comb begin
    int ci;
    ci = 0;
    for (int c = 0; c < MAX_WORD_LEN; c++) begin
      ci = int'(len_eff) - 1 - c;
      cand[c] = '0;
      if (c < int'(len_eff)) begin
        cand[c] = rec_q[ci[PW-1:0]];
      end
    end
  end

  assign target = mode_dict_q ? stage_q : cand;

  // Compare the fetched dictionary word over the first word_len characters
  logic srch_eq;
  always_comb begin
    srch_eq = 1'b1;
    for (int c = 0; c < MAX_WORD_LEN; c++) begin
      if ((c < int'(len_eff)) && (dm_rd_q[c] != target[c])) begin
        srch_eq = 1'b0;
      end
    end
  end

  // Window of the current phase
  logic [KW-1:0]   cur_matched, matched_new;
  logic [ID_W-1:0] cur_head, head_nxt, tail_id;
  logic [TIB-1:0]  cur_start;
  logic [ID_W:0]   tsum, tail;
  logic [CW-1:0]   cnt_cur, cnt_inc;
  logic            not_full, hit, load;
  logic [PW-1:0]   ph_nxt;

  assign cur_matched = matched_q[ph_q];
  assign cur_head    = head_q[ph_q];
  assign cur_start   = wstart_q[ph_q];
  assign cnt_cur     = c_rv_q ? c_rd_q : '0;
  assign cnt_inc     = cnt_cur + CW'(1);
  assign not_full    = 8'(cur_matched) < 8'(MAX_WORDS);
  assign matched_new = not_full ? cur_matched + KW'(1) : cur_matched;
  assign hit         = (matched_new == cnt_eff);
  assign load        = cmd_i.append && hit;
  assign tsum        = (ID_W+1)'(cur_head) + (ID_W+1)'(cur_matched);
  assign tail        = (tsum >= (ID_W+1)'(MAX_WORDS)) ? tsum - (ID_W+1)'(MAX_WORDS) : tsum;
  assign tail_id     = tail[ID_W-1:0];
  assign head_nxt    = (cur_head == ID_W'(MAX_WORDS - 1)) ? '0 : cur_head + ID_W'(1);
  assign ph_nxt      = ((8'(phase_q) + 8'd1) == 8'(len_eff)) ? '0 : phase_q + PW'(1);

  // Count memory ports
  logic          c_we;
  logic [SW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata;

  assign c_we    = cmd_i.w_inc || (cmd_i.sh_dec && (cnt_cur != '0));
  assign c_waddr = cmd_i.w_inc ? slot(ph_q, id_q) : slot(ph_q, old_q);
  assign c_wdata = cmd_i.w_inc ? cnt_inc : cnt_cur - CW'(1);
  assign c_raddr = cmd_i.sh_cnt ? slot(ph_q, h_rd_q) : slot(ph_q, id_q);

  // Status
  always_comb begin
    sts_o             = '0;
    sts_o.req_text    = (req_type_i == REQ_TEXT);
    sts_o.dict_end    = (req_type_i == REQ_DICT) && word_end;
    sts_o.ph_big      = 8'(phase_q) >= 8'(len_eff);
    sts_o.fill_short  = 8'(fill_q) < 8'(len_eff);
    sts_o.srch_more   = j_q < dk_q;
    sts_o.srch_eq     = srch_eq;
    sts_o.mode_dict   = mode_dict_q;
    sts_o.cnt_over    = 8'(cnt_inc) > 8'(reqc_q[id_q]);
    sts_o.win_empty   = (cur_matched == '0);
    sts_o.old_is_id   = (old_q == id_q);
    sts_o.out_blocked = out_v_q && match_stall_i;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dk_q        <= '0;
      dpos_q      <= '0;
      fill_q      <= '0;
      tpos_q      <= '0;
      phase_q     <= '0;
      ph_q        <= '0;
      mode_dict_q <= 1'b0;
      j_q         <= '0;
      out_v_q     <= 1'b0;
      for (int i = 0; i < MAX_WORDS; i++) begin
        reqc_q[i] <= '0;
      end
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        rec_q[i]     <= '0;
        wstart_q[i]  <= '0;
        matched_q[i] <= '0;
        head_q[i]    <= '0;
      end
    end else begin
      if (restart) begin
        dk_q    <= '0;
        dpos_q  <= '0;
        fill_q  <= '0;
        tpos_q  <= '0;
        phase_q <= '0;
        for (int i = 0; i < MAX_WORDS; i++) begin
          reqc_q[i] <= '0;
        end
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
          rec_q[i]     <= '0;
          wstart_q[i]  <= '0;
          matched_q[i] <= '0;
          head_q[i]    <= '0;
        end
      end
      // Dictionary character: advance inside the word or start the duplicate search
      if (dict_acc && dict_open) begin
        if (word_end) begin
          mode_dict_q <= 1'b1;
          j_q         <= '0;
        end else begin
          dpos_q <= dpos_q + PW'(1);
        end
      end
      // Text character: shift history, advance position
      if (text_acc) begin
        rec_q[0] <= char_byte_i;
        for (int i = 1; i < MAX_WORD_LEN; i++) begin
          rec_q[i] <= rec_q[i-1];
        end
        if (8'(fill_q) < 8'(MAX_WORD_LEN)) begin
          fill_q <= fill_q + LEN_W'(1);
        end
        tpos_q      <= tpos_q + TIB'(1);
        mode_dict_q <= 1'b0;
        j_q         <= '0;
      end
      if (cmd_i.ph_sub) begin
        phase_q <= phase_q - PW'(len_eff);
      end
      if (cmd_i.ph_step) begin
        phase_q <= ph_nxt;
        ph_q    <= ph_nxt;
      end
      if (cmd_i.srch_cmp && !srch_eq) begin
        j_q <= j_q + KW'(1);
      end
      if (cmd_i.dict_fin) begin
        reqc_q[id_q] <= reqc_q[id_q] + KW'(1);
        dk_q         <= dk_q + KW'(1);
        dpos_q       <= '0;
      end
      // Unknown word: empty the window
      if (cmd_i.miss) begin
        matched_q[ph_q] <= '0;
        head_q[ph_q]    <= '0;
      end
      if (cmd_i.w_init && (cur_matched == '0)) begin
        wstart_q[ph_q] <= start_q;
        head_q[ph_q]   <= '0;
      end
      // Drop the oldest word of the window
      if (cmd_i.sh_dec) begin
        head_q[ph_q]    <= head_nxt;
        wstart_q[ph_q]  <= cur_start + TIB'(len_eff);
        matched_q[ph_q] <= cur_matched - KW'(1);
      end
      if (cmd_i.append) begin
        matched_q[ph_q] <= matched_new;
      end
      // Result register
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !match_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (dict_acc && dict_open) begin
      stage_q <= new_word;
      if (word_end) begin
        id_q <= dk_q[ID_W-1:0];
      end
    end
    if (text_acc) begin
      start_q <= tpos_q - TIB'(len_eff) + TIB'(1);
    end
    if (cmd_i.srch_cmp && srch_eq) begin
      id_q <= ident_q[j_q[ID_W-1:0]];
    end
    if (cmd_i.dict_fin) begin
      ident_q[dk_q[ID_W-1:0]] <= id_q;
    end
    if (cmd_i.sh_cnt) begin
      old_q <= h_rd_q;
    end
    if (load) begin
      out_q <= cur_start;
    end
  end

  // Dictionary word memory
  always_ff @(posedge clk_i) begin
    if (dict_acc && word_end) begin
      dmem[dk_q[ID_W-1:0]] <= new_word;
    end
    dm_rd_q <= dmem[j_q[ID_W-1:0]];
  end

  // Window count memory
  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_rd_q <= cmem[c_raddr];
  end

  // Count valid bits; an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        cvld_q[i] <= 1'b0;
      end
      c_rv_q <= 1'b0;
    end else begin
      c_rv_q <= cvld_q[c_raddr];
      if (restart) begin
        for (int i = 0; i < SLOTS; i++) begin
          cvld_q[i] <= 1'b0;
        end
      end else begin
        if (cmd_i.miss) begin
          for (int i = 0; i < MAX_WORDS; i++) begin
            cvld_q[slot(ph_q, ID_W'(i))] <= 1'b0;
          end
        end
        if (c_we) begin
          cvld_q[c_waddr] <= 1'b1;
        end
      end
    end
  end

  // Window history memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && not_full) begin
      hmem[slot(ph_q, tail_id)] <= id_q;
    end
    h_rd_q <= hmem[slot(ph_q, cur_head)];
  end

  // Output
  logic [TIB+MATCH_W-1:0] out_ext;
  assign out_ext       = {{MATCH_W{1'b0}}, out_q};
  assign match_start_o = out_ext[MATCH_W-1:0];
  assign match_valid_o = out_v_q;

endmodule

/* rtl/wcf_checker.sv */
// Port-level checks of the word concatenation finder, bound to the top level.
module wcf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [wcf_pkg::REQ_W-1:0]   req_type_i,
  input logic                        match_valid_o,
  input logic                        match_stall_i,
  input logic [wcf_pkg::MATCH_W-1:0] match_start_o
);
  import wcf_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_o && match_stall_i |=> match_valid_o && $stable(match_start_o))
    else $error("stalled result changed");

  // A restart never produces a result
  a_restart_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i == REQ_RESTART) && !match_valid_o |=> !match_valid_o)
    else $error("result after restart");

  // A dictionary character never produces a result
  a_dict_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i == REQ_DICT) && !match_valid_o |=> !match_valid_o)
    else $error("result after dictionary character");

  // A text character always stalls the input after it is taken
  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i == REQ_TEXT) |=> in_stall_o)
    else $error("text character finished in one cycle");

endmodule

bind word_concatenation_finder_unit wcf_checker u_wcf_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the word concatenation finder unit.
`timescale 1ns / 1ps

module tb;
  import wcf_pkg::*;

  localparam int unsigned WLEN_MAX = 16;
  localparam int unsigned WORDS_MAX = 16;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [CHAR_W-1:0]   char_byte_i;
  logic                match_valid_o;
  logic                match_stall_i;
  logic [MATCH_W-1:0]  match_start_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  word_concatenation_finder_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .req_type_i(req_type_i), .char_byte_i(char_byte_i),
    .match_valid_o(match_valid_o), .match_stall_i(match_stall_i),
    .match_start_o(match_start_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bookkeeping
  logic [MATCH_W-1:0] expected_starts[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned matches_seen;
  bit          idle_on;
  int unsigned hold_cycles;

  // Shadow of the finder state
  int unsigned  len_reg, cnt_reg;
  byte unsigned dict_mem[WLEN_MAX*WORDS_MAX];
  int unsigned  dict_fill;
  byte unsigned word_id[WORDS_MAX];
  byte unsigned need_cnt[WORDS_MAX];
  byte unsigned recent[WLEN_MAX];
  int unsigned  recent_n;
  logic [15:0]  text_pos;
  int unsigned  phase;
  logic [15:0]  win_start[WLEN_MAX];
  int unsigned  win_matched[WLEN_MAX];
  byte unsigned win_cnt[WLEN_MAX*WORDS_MAX];
  byte unsigned win_hist[WLEN_MAX*WORDS_MAX];
  int unsigned  hist_head[WLEN_MAX];

  function automatic int unsigned len_eff();
    if (len_reg < 1) return 1;
    if (len_reg > WLEN_MAX) return WLEN_MAX;
    return len_reg;
  endfunction

  function automatic int unsigned cnt_eff();
    if (cnt_reg < 1) return 1;
    if (cnt_reg > WORDS_MAX) return WORDS_MAX;
    return cnt_reg;
  endfunction

  function automatic void clear_finder();
    foreach (dict_mem[i]) begin
      dict_mem[i] = 0;
      win_cnt[i] = 0;
      win_hist[i] = 0;
    end
    foreach (word_id[i]) begin
      word_id[i] = 0;
      need_cnt[i] = 0;
    end
    foreach (recent[i]) begin
      recent[i] = 0;
      win_start[i] = 0;
      win_matched[i] = 0;
      hist_head[i] = 0;
    end
    dict_fill = 0;
    recent_n = 0;
    text_pos = 0;
    phase = 0;
  endfunction

  function automatic bit dict_same(int unsigned a, int unsigned b, int unsigned len);
    for (int unsigned c = 0; c < len; c++)
      if (dict_mem[a*WLEN_MAX+c] != dict_mem[b*WLEN_MAX+c]) return 0;
    return 1;
  endfunction

  // Store one dictionary character; a finished word gets its identity
  function automatic void dict_add(byte unsigned ch);
    int unsigned len = len_eff();
    int unsigned k = dict_fill / WLEN_MAX;
    int unsigned pos = dict_fill % WLEN_MAX;
    int unsigned id;
    if (k >= cnt_eff() || k >= WORDS_MAX) return;
    dict_mem[k*WLEN_MAX+pos] = ch;
    if (pos + 1 < len && pos + 1 < WLEN_MAX) begin
      dict_fill++;
      return;
    end
    id = k;
    for (int unsigned j = 0; j < k; j++) begin
      if (dict_same(j, k, len)) begin
        id = word_id[j] % WORDS_MAX;
        break;
      end
    end
    word_id[k] = 8'(id);
    need_cnt[id]++;
    dict_fill = (k + 1) * WLEN_MAX;
  endfunction

  // Advance the text by one character; returns 1 when a window completes
  function automatic bit text_add(byte unsigned ch, output logic [15:0] start_o);
    int unsigned len = len_eff();
    logic [15:0] p = text_pos;
    int unsigned ph, base, nwords, id, hd, old, tail;
    logic [15:0] wstart;
    bit found, same;
    start_o = '0;
    id = 0;
    found = 0;
    for (int i = 0; i < WLEN_MAX - 1; i++) recent[i] = recent[i+1];
    recent[WLEN_MAX-1] = ch;
    if (recent_n < WLEN_MAX) recent_n++;
    text_pos = p + 16'd1;
    ph = ((phase % len) + 1) % len;
    phase = ph;
    if (recent_n < len) return 0;
    wstart = p - 16'(len) + 16'd1;
    nwords = dict_fill / WLEN_MAX;
    if (nwords > WORDS_MAX) nwords = WORDS_MAX;
    for (int unsigned j = 0; j < nwords && !found; j++) begin
      same = 1;
      for (int unsigned c = 0; c < len; c++)
        if (dict_mem[j*WLEN_MAX+c] != recent[WLEN_MAX-len+c]) same = 0;
      if (same) begin
        found = 1;
        id = word_id[j] % WORDS_MAX;
      end
    end
    base = ph * WORDS_MAX;
    // Unknown word empties this phase's window
    if (!found) begin
      win_matched[ph] = 0;
      hist_head[ph] = 0;
      for (int unsigned i = 0; i < WORDS_MAX; i++) win_cnt[base+i] = 0;
      return 0;
    end
    if (win_matched[ph] == 0) begin
      win_start[ph] = wstart;
      hist_head[ph] = 0;
    end
    win_cnt[base+id]++;
    // Surplus word: drop from the front up to and including its earlier copy
    if (win_cnt[base+id] > need_cnt[id]) begin
      while (win_matched[ph] > 0) begin
        hd = hist_head[ph] % WORDS_MAX;
        old = win_hist[base+hd] % WORDS_MAX;
        if (win_cnt[base+old] > 0) win_cnt[base+old]--;
        hist_head[ph] = (hd + 1) % WORDS_MAX;
        win_start[ph] = win_start[ph] + 16'(len);
        win_matched[ph]--;
        if (old == id) break;
      end
    end
    if (win_matched[ph] < WORDS_MAX) begin
      tail = (hist_head[ph] + win_matched[ph]) % WORDS_MAX;
      win_hist[base+tail] = 8'(id);
      win_matched[ph]++;
    end
    if (win_matched[ph] == cnt_eff()) begin
      start_o = win_start[ph];
      return 1;
    end
    return 0;
  endfunction

  // Clock and timeout
  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // Check every result transfer against the oldest expectation
  initial begin
    logic [MATCH_W-1:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && match_valid_o && !match_stall_i) begin
        matches_seen++;
        if (expected_starts.size() == 0) begin
          $error("unexpected result match_start=%0d", match_start_o);
          errors++;
        end else begin
          want = expected_starts.pop_front();
          if (match_start_o !== want) begin
            $error("match_start: expected %0d, actual %0d", want, match_start_o);
            errors++;
          end
        end
      end
    end
  end

  // Receiver stalls: random bursts plus requested long hold-offs
  initial begin
    int unsigned burst;
    burst = 0;
    match_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        match_stall_i <= 1;
      end else if (burst > 0) begin
        burst--;
        match_stall_i <= 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        match_stall_i <= 1;
      end else begin
        match_stall_i <= 0;
      end
    end
  end

  // Offer one item, hold it until the transfer, then update the shadow state
  task automatic send_item(logic [REQ_W-1:0] req, byte unsigned ch);
    logic [15:0] start;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    req_type_i  <= req;
    char_byte_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    case (req)
      REQ_DICT: dict_add(ch);
      REQ_TEXT: if (text_add(ch, start)) expected_starts.insert(expected_starts.size(), start);
      REQ_RESTART: clear_finder();
      default: ;
    endcase
  endtask

  task automatic send_string(logic [REQ_W-1:0] req, string s);
    for (int i = 0; i < s.len(); i++) send_item(req, s[i]);
  endtask

  // Drop valid, wait for all results and for any trailing work
  task automatic settle();
    in_valid_i <= 0;
    while (expected_starts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    if (reg_idx == REG_WORD_LEN) len_reg = value & 31;
    else cnt_reg = value & 31;
  endtask

  task automatic configure(logic [31:0] len, logic [31:0] cnt);
    settle();
    write_reg(REG_WORD_LEN, len);
    write_reg(REG_WORD_COUNT, cnt);
    send_item(REQ_RESTART, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_defaults();
    send_item(REQ_DICT, "x");
    send_string(REQ_TEXT, "axxb");
    send_item(REQ_SPARE, 8'hff);
    send_item(REQ_TEXT, "x");
  endtask

  task automatic test_directed();
    configure(3, 3);
    // text before the dictionary is complete
    send_string(REQ_DICT, "foo");
    send_string(REQ_TEXT, "foofoo");
    send_string(REQ_DICT, "barfoo");
    // surplus dictionary characters are ignored
    send_string(REQ_DICT, "zz");
    send_string(REQ_TEXT, "barfoofoobarfoofooqq");
    send_item(REQ_TEXT, 8'h00);
    send_item(REQ_TEXT, 8'hff);
    send_string(REQ_TEXT, "foobarfoo");
  endtask

  task automatic test_extremes();
    // out-of-range values clamp
    configure(0, 0);
    send_item(REQ_DICT, 8'h00);
    send_string(REQ_TEXT, "\001");
    send_item(REQ_TEXT, 8'h00);
    // longest words: two words of sixteen characters
    configure(32'hffff_ffff, 2);
    for (int i = 0; i < 32; i++) send_item(REQ_DICT, (i < 16) ? 8'h01 : 8'h11);
    for (int w = 0; w < 4; w++)
      for (int c = 0; c < 16; c++) send_item(REQ_TEXT, (w == 1) ? 8'h01 : 8'h11);
    // most words: sixteen single characters, four copies of each
    configure(1, 20);
    for (int i = 0; i < 16; i++) send_item(REQ_DICT, 8'(8'h61 + i % 4));
    for (int i = 0; i < 40; i++) send_item(REQ_TEXT, 8'(8'h61 + i % 4));
  endtask

  task automatic test_midstream();
    configure(3, 2);
    send_string(REQ_DICT, "abcabd");
    send_string(REQ_TEXT, "abcabdab");
    // shorter words keep the state; extra characters are not compared
    settle();
    write_reg(REG_WORD_LEN, 2);
    send_string(REQ_TEXT, "abababcab");
    settle();
    write_reg(REG_WORD_COUNT, 1);
    send_string(REQ_TEXT, "abab");
  endtask

  task automatic test_random();
    byte unsigned words[WORDS_MAX][WLEN_MAX];
    byte unsigned alpha[3];
    int unsigned len, cnt, start_items, pick, wsel;
    start_items = items_sent;
    while (items_sent - start_items < 200) begin
      len = $urandom_range(1, 4);
      cnt = $urandom_range(1, 4);
      configure(len, cnt);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      for (int w = 0; w < cnt; w++)
        for (int c = 0; c < len; c++) words[w][c] = alpha[$urandom_range(0, 1)];
      for (int w = 0; w < cnt; w++)
        for (int c = 0; c < len; c++) send_item(REQ_DICT, words[w][c]);
      for (int t = 0; t < 30; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          wsel = $urandom_range(0, cnt - 1);
          for (int c = 0; c < len; c++) send_item(REQ_TEXT, words[wsel][c]);
        end else if (pick < 90) begin
          send_item(REQ_TEXT, 8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
          send_item(REQ_SPARE, 8'($urandom_range(0, 255)));
        end else if (pick < 98) begin
          send_item(REQ_DICT, alpha[2]);
        end else begin
          // restart mid-text, then rebuild the same dictionary
          send_item(REQ_RESTART, 8'($urandom_range(0, 255)));
          for (int w = 0; w < cnt; w++)
            for (int c = 0; c < len; c++) send_item(REQ_DICT, words[w][c]);
        end
      end
    end
  endtask

  task automatic test_pressure();
    configure(1, 1);
    send_item(REQ_DICT, "a");
    hold_cycles = 400;
    repeat (60) send_item(REQ_TEXT, "a");
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    matches_seen = 0;
    hold_cycles = 0;
    idle_on = 1;
    rst_ni = 0;
    in_valid_i = 0;
    req_type_i = REQ_DICT;
    char_byte_i = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    len_reg = 1;
    cnt_reg = 1;
    clear_finder();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    test_defaults();
    test_directed();
    test_extremes();
    test_midstream();
    test_random();
    idle_on = 0;
    test_pressure();
    settle();

    $display("Covered defaults, duplicate words, clamped word length and count, mid-stream");
    $display("config, random streams and output back-pressure: %0d items, %0d matches",
             items_sent, matches_seen);
    if (errors == 0 && expected_starts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/wcf_pkg.sv
rtl/wcf_ctrl.sv
rtl/wcf_dp.sv
rtl/word_concatenation_finder_unit.sv
rtl/wcf_checker.sv
sim/tb.sv
